@@ design/integer_matrix_2x2_decrypt_defines.svh @@
// Assertion macros shared by the 2x2 integer matrix decryption RTL.
`ifndef INTEGER_MATRIX_2X2_DECRYPT_DEFINES_SVH
`define INTEGER_MATRIX_2X2_DECRYPT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define IMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define IMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/imd_pkg.sv @@
// Types and constants shared by the 2x2 integer matrix decryption modules.
`default_nettype none

package imd_pkg;

  localparam int KeyW    = 16;
  localparam int CipherW = 32;
  localparam int PlainW  = 7;
  localparam int DetW    = 33;
  localparam int DetMagW = 32;
  localparam int RowW    = 48;
  localparam int MagW    = 48;
  localparam int QuotW   = 7;
  localparam int Lanes   = 2;
  localparam int KeyIdxW = 2;

  localparam int PrintLow  = 32;
  localparam int PrintHigh = 126;

  typedef enum logic [KeyIdxW-1:0] {
    KeyTopLeft,
    KeyTopRight,
    KeyBottomLeft,
    KeyBottomRight
  } key_idx_e;

  typedef struct packed {
    logic signed [CipherW-1:0] cipher_first;
    logic signed [CipherW-1:0] cipher_second;
  } in_t;

  typedef struct packed {
    logic [PlainW-1:0] plain_first;
    logic              first_valid;
    logic [PlainW-1:0] plain_second;
    logic              second_valid;
    logic              singular_key;
  } out_t;

  typedef struct packed {
    logic signed [KeyW-1:0] a;
    logic signed [KeyW-1:0] b;
    logic signed [KeyW-1:0] c;
    logic signed [KeyW-1:0] d;
  } key_t;

  // Magnitude, sign and zero flag of the key determinant.
  typedef struct packed {
    logic [DetMagW-1:0] mag;
    logic               neg;
    logic               zero;
  } det_t;

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic            neg;
  } row_lane_t;

  typedef struct packed {
    row_lane_t [Lanes-1:0] lane;
  } rows_item_t;

  typedef struct packed {
    logic [MagW-1:0]  rem;
    logic [QuotW-1:0] quot;
    logic             bad;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [Lanes-1:0] lane;
    logic                  singular;
  } div_item_t;

endpackage

`default_nettype wire

@@ design/imd_key.sv @@
// Key registers and the registered determinant of the key matrix.
`default_nettype none

module imd_key (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [imd_pkg::KeyIdxW-1:0] wr_index_i,
  input  logic [imd_pkg::KeyW-1:0]   wr_data_i,
  output imd_pkg::key_t              key_o,
  output imd_pkg::det_t              det_o
);
  import imd_pkg::*;

  key_t                   key_q;
  logic signed [DetW-1:0] det_q;
  logic signed [DetW-1:0] det_d;
  logic signed [DetW-1:0] det_neg;
  logic signed [31:0]     prod_ad;
  logic signed [31:0]     prod_bc;
  det_t                   info_q;
  det_t                   info_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q.a <= KeyW'(1);
      key_q.b <= '0;
      key_q.c <= '0;
      key_q.d <= KeyW'(1);
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        KeyTopLeft:     key_q.a <= wr_data_i;
        KeyTopRight:    key_q.b <= wr_data_i;
        KeyBottomLeft:  key_q.c <= wr_data_i;
        KeyBottomRight: key_q.d <= wr_data_i;
        default:        key_q   <= key_q;
      endcase
    end
  end

  always_comb begin
    prod_ad = $signed(key_q.a) * $signed(key_q.d);
    prod_bc = $signed(key_q.b) * $signed(key_q.c);
    det_d   = $signed({prod_ad[31], prod_ad}) - $signed({prod_bc[31], prod_bc});
    det_neg = -det_q;
    info_d.neg  = det_q[DetW-1];
    info_d.zero = (det_q == '0);
    info_d.mag  = det_q[DetW-1] ? det_neg[DetMagW-1:0] : det_q[DetMagW-1:0];
  end

  // The determinant is registered in det_q and then again in info_q, behind the key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q       <= DetW'(1);
      info_q.mag  <= DetMagW'(1);
      info_q.neg  <= 1'b0;
      info_q.zero <= 1'b0;
    end else begin
      det_q  <= det_d;
      info_q <= info_d;
    end
  end

  assign key_o = key_q;
  assign det_o = info_q;

endmodule

`default_nettype wire

@@ design/imd_rows.sv @@
// Three-stage front end: adjugate products, row sums, and row magnitudes.
`default_nettype none

module imd_rows (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imd_pkg::key_t       key_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  imd_pkg::in_t        in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output imd_pkg::rows_item_t out_data_o
);
  import imd_pkg::*;

  typedef struct packed {
    logic signed [RowW-1:0] dx;
    logic signed [RowW-1:0] by;
    logic signed [RowW-1:0] ay;
    logic signed [RowW-1:0] cx;
  } prod_t;

  typedef struct packed {
    logic signed [RowW-1:0] row0;
    logic signed [RowW-1:0] row1;
  } sum_t;

  prod_t      prod_q, prod_d;
  sum_t       sum_q, sum_d;
  rows_item_t mag_q, mag_d;
  logic       v1_q, v2_q, v3_q;
  logic       rdy1, rdy2, rdy3;
  logic signed [RowW-1:0] neg0, neg1;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  always_comb begin
    prod_d.dx = $signed(key_i.d) * $signed(in_data_i.cipher_first);
    prod_d.by = $signed(key_i.b) * $signed(in_data_i.cipher_second);
    prod_d.ay = $signed(key_i.a) * $signed(in_data_i.cipher_second);
    prod_d.cx = $signed(key_i.c) * $signed(in_data_i.cipher_first);

    sum_d.row0 = prod_q.dx - prod_q.by;
    sum_d.row1 = prod_q.ay - prod_q.cx;

    neg0 = -sum_q.row0;
    neg1 = -sum_q.row1;
    mag_d.lane[0].neg = sum_q.row0[RowW-1];
    mag_d.lane[0].mag = sum_q.row0[RowW-1] ? MagW'(neg0) : MagW'(sum_q.row0);
    mag_d.lane[1].neg = sum_q.row1[RowW-1];
    mag_d.lane[1].mag = sum_q.row1[RowW-1] ? MagW'(neg1) : MagW'(sum_q.row1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) prod_q <= prod_d;
    if (rdy2 && v1_q)       sum_q  <= sum_d;
    if (rdy3 && v2_q)       mag_q  <= mag_d;
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;
  assign out_data_o  = mag_q;

endmodule

`default_nettype wire

@@ design/imd_div.sv @@
// Pipelined restoring divider: range check stage, then one quotient bit per stage.
`default_nettype none

module imd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imd_pkg::det_t       det_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  imd_pkg::rows_item_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output imd_pkg::div_item_t  out_data_o
);
  import imd_pkg::*;

  localparam int Depth = QuotW + 1;

  div_item_t        st_q [Depth];
  div_item_t        st_d [Depth];
  logic [Depth-1:0] v_q;
  logic [Depth:0]   rdy;
  logic [MagW-1:0]  lim;

  always_comb begin
    rdy[Depth] = out_ready_i;
    for (int s = Depth - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end

  always_comb begin
    lim = '0;
    // A quotient is only usable when it is positive and below 128, so a
    // sign mismatch, a zero determinant or a row of 128 determinants or more marks the lane bad.
    for (int l = 0; l < Lanes; l++) begin
      st_d[0].lane[l].rem  = in_data_i.lane[l].mag;
      st_d[0].lane[l].quot = '0;
      st_d[0].lane[l].bad  = det_i.zero
                          || (in_data_i.lane[l].neg != det_i.neg)
                          || (in_data_i.lane[l].mag >= (MagW'(det_i.mag) << QuotW));
    end
    st_d[0].singular = det_i.zero;

    for (int s = 1; s < Depth; s++) begin
      st_d[s] = st_q[s-1];
      for (int l = 0; l < Lanes; l++) begin
        lim = MagW'(det_i.mag) << (QuotW - s);
        if (st_q[s-1].lane[l].rem >= lim) begin
          st_d[s].lane[l].rem             = st_q[s-1].lane[l].rem - lim;
          st_d[s].lane[l].quot[QuotW - s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < Depth; s++) begin
        if (rdy[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) st_q[0] <= st_d[0];
    for (int s = 1; s < Depth; s++) begin
      if (rdy[s] && v_q[s-1]) st_q[s] <= st_d[s];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Depth-1];
  assign out_data_o  = st_q[Depth-1];

endmodule

`default_nettype wire

@@ design/integer_matrix_2x2_decrypt.sv @@
// Top level of the 2x2 integer matrix decryption pipeline.
`default_nettype none

`include "integer_matrix_2x2_decrypt_defines.svh"

// This block decodes pairs of 32-bit cipher integers with a 2x2 key matrix
// [[a, b], [c, d]] held in four 16-bit configuration registers (index 0 to 3:
// top left, top right, bottom left, bottom right; reset to the identity).
// Each pair (x, y) yields one result: trunc((d*x - b*y) / det) and
// trunc((a*y - c*x) / det), where det = a*d - b*c. A decoded value that is
// printable ASCII (32 to 126) is delivered with its valid flag set; otherwise
// the code is zero and the flag is clear. A zero determinant raises
// singular_key and clears both flags. The block accepts one pair in every
// cycle and delivers one result per cycle while the output is not stalled.
// The pipeline has three stages for the products, row sums and magnitudes,
// eight stages for the divider (one range check plus one quotient bit per
// stage, as the quotient needs seven bits), and the output register. Every
// stage has its own valid bit, so bubbles close up under a stall, and new
// pairs are still taken while a finished result waits as long as some
// stage is empty. The configuration port is always ready. Keys may only
// be written while no transfer is in flight; the determinant is registered
// behind the key registers and settles before any new pair reaches the
// divider.
module integer_matrix_2x2_decrypt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  imd_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output imd_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [imd_pkg::KeyIdxW-1:0] cfg_index_i,
  input  logic [imd_pkg::KeyW-1:0]    cfg_data_i
);
  import imd_pkg::*;

  key_t       key;
  det_t       det;
  logic       rows_in_ready;
  logic       rows_valid;
  logic       div_in_ready;
  rows_item_t rows_data;
  logic       div_valid;
  logic       out_ready;
  div_item_t  div_data;
  out_t       out_q, out_d;
  logic       out_valid_q;
  logic [1:0] lane_ok;

  // Key writes are never held off.
  assign cfg_ready_o = 1'b1;

  imd_key u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .key_o      (key),
    .det_o      (det)
  );

  imd_rows u_rows (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (rows_in_ready),
    .in_data_i   (in_data_i),
    .out_valid_o (rows_valid),
    .out_ready_i (div_in_ready),
    .out_data_o  (rows_data)
  );

  imd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .det_i       (det),
    .in_valid_i  (rows_valid),
    .in_ready_o  (div_in_ready),
    .in_data_i   (rows_data),
    .out_valid_o (div_valid),
    .out_ready_i (out_ready),
    .out_data_o  (div_data)
  );

  assign in_stall_o = !rows_in_ready;
  assign out_ready  = !out_valid_q || !out_stall_i;

  // A lane is printable when the divider found no sign, overflow or zero-determinant problem
  // and the seven-bit quotient lies in the printable range.
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      lane_ok[l] = !div_data.lane[l].bad
                && (div_data.lane[l].quot >= QuotW'(PrintLow))
                && (div_data.lane[l].quot <= QuotW'(PrintHigh));
    end
    out_d.plain_first  = lane_ok[0] ? PlainW'(div_data.lane[0].quot) : '0;
    out_d.first_valid  = lane_ok[0];
    out_d.plain_second = lane_ok[1] ? PlainW'(div_data.lane[1].quot) : '0;
    out_d.second_valid = lane_ok[1];
    out_d.singular_key = div_data.singular;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && div_valid) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The input can only back up when every stage is full behind a stalled result.
  `IMD_ASSERT_IMP(a_stall_needs_full_out, in_stall_o, out_valid_o && out_stall_i, "input stalled while output free")
  // A singular key never yields characters.
  `IMD_ASSERT_IMP(a_singular_no_chars, out_valid_o && out_data_o.singular_key, !out_data_o.first_valid && !out_data_o.second_valid, "character on singular key")
  // A flagged first code is printable, an unflagged one is zero.
  `IMD_ASSERT_IMP(a_first_code, out_valid_o && out_data_o.first_valid, (out_data_o.plain_first >= PlainW'(PrintLow)) && (out_data_o.plain_first <= PlainW'(PrintHigh)), "first code outside printable range")
  `IMD_ASSERT_IMP(a_first_zero, out_valid_o && !out_data_o.first_valid, out_data_o.plain_first == '0, "invalid first code not zero")
  `IMD_ASSERT_IMP(a_second_zero, out_valid_o && !out_data_o.second_valid, out_data_o.plain_second == '0, "invalid second code not zero")
  // A result that is not taken is still offered in the next cycle.
  `IMD_ASSERT_NXT(a_result_kept, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")

endmodule

`default_nettype wire

@@ dv/tb_integer_matrix_2x2_decrypt.sv @@
// Self-checking testbench for the 2x2 integer matrix decryption block.
`default_nettype none

module tb_integer_matrix_2x2_decrypt;
  import imd_pkg::*;

  localparam int HalfPeriod   = 6;
  localparam int ResetCycles  = 10;
  localparam int DrainCycles  = 16;     // settling time after the queues drain
  localparam int HoldCycles   = 300;    // long output hold-off, far beyond the pipeline depth
  localparam int PhaseItems   = 200;
  localparam int RandomPhases = 8;
  localparam int CycleLimit   = 200000;
  localparam int PrintCap     = 40;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef enum int {
    KeySmall,
    KeyFull,
    KeyEdge,
    KeySingular
  } key_kind_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [KeyIdxW-1:0]  cfg_index_i = '0;
  logic [KeyW-1:0]     cfg_data_i  = '0;

  integer_matrix_2x2_decrypt uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Local copy of the key registers, updated when a configuration write is accepted.
  logic signed [KeyW-1:0] key_val [4] = '{16'sd1, 16'sd0, 16'sd0, 16'sd1};

  in_t  pending_pairs[$];
  out_t expected_plain[$];

  int   snd_idle_pct  = 0;
  int   rcv_stall_pct = 0;
  bit   hold_start    = 1'b0;
  int   hold_left     = 0;
  bit   in_took       = 1'b0;
  int   error_count   = 0;
  int   cycle_count   = 0;

  // A quotient becomes a code only when it is printable ASCII.
  function automatic void to_code(input longint q, output logic [PlainW-1:0] code,
                                  output logic ok);
    ok   = (q >= PrintLow) && (q <= PrintHigh);
    code = ok ? q[PlainW-1:0] : '0;
  endfunction

  // Decodes one cipher pair with the current key: adjugate times the pair,
  // each row divided by the determinant with truncation toward zero.
  function automatic out_t decode_pair(in_t pair);
    longint a, b, c, d, x, y, det;
    out_t   res;
    a   = longint'(key_val[KeyTopLeft]);
    b   = longint'(key_val[KeyTopRight]);
    c   = longint'(key_val[KeyBottomLeft]);
    d   = longint'(key_val[KeyBottomRight]);
    x   = longint'(pair.cipher_first);
    y   = longint'(pair.cipher_second);
    det = a * d - b * c;
    res = '0;
    if (det == 0) begin
      res.singular_key = 1'b1;
    end else begin
      to_code((d * x - b * y) / det, res.plain_first, res.first_valid);
      to_code((a * y - c * x) / det, res.plain_second, res.second_valid);
    end
    return res;
  endfunction

  // Encrypts a plaintext pair with the current key and adds a small offset to
  // each cipher value, which moves the exact quotient off an integer.
  function automatic in_t encode_pair(longint p, longint q, longint dx, longint dy);
    longint x, y;
    in_t    res;
    x = longint'(key_val[KeyTopLeft]) * p + longint'(key_val[KeyTopRight]) * q + dx;
    y = longint'(key_val[KeyBottomLeft]) * p + longint'(key_val[KeyBottomRight]) * q + dy;
    res.cipher_first  = x[CipherW-1:0];
    res.cipher_second = y[CipherW-1:0];
    return res;
  endfunction

  function automatic logic [CipherW-1:0] edge_cipher();
    case ($urandom_range(8))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return 32'h0000_0001;
      5:       return PrintLow;
      6:       return PrintHigh;
      7:       return PrintHigh + 1;
      default: return PrintLow - 1;
    endcase
  endfunction

  // Appends one pair to the end of the driver queue.
  task automatic queue_pair(in_t pair);
    pending_pairs.insert(pending_pairs.size(), pair);
  endtask

  task automatic report_mismatch(string msg);
    if (error_count < PrintCap) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Waits until the input queue is empty, the last transfer is gone and every
  // expected result has arrived, then lets the pipeline settle.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_pairs.size() != 0 || in_valid_i || expected_plain.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes all four key registers; only called while the block is idle.
  task automatic write_keys(logic signed [KeyW-1:0] ka, logic signed [KeyW-1:0] kb,
                            logic signed [KeyW-1:0] kc, logic signed [KeyW-1:0] kd);
    logic signed [KeyW-1:0] vals [4];
    vals = '{ka, kb, kc, kd};
    wait_drained();
    for (int k = 0; k < $size(vals); k++) begin
      @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= key_idx_e'(k);
      cfg_data_i  <= vals[k];
      do @(posedge clk_i);
      while (!cfg_ready_o);
      key_val[k] = vals[k];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IdleNone: begin
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
      end
      IdleSender: begin
        snd_idle_pct  = 69;
        rcv_stall_pct = 0;
      end
      IdleReceiver: begin
        snd_idle_pct  = 0;
        rcv_stall_pct = 69;
      end
      default: begin
        snd_idle_pct  = 38;
        rcv_stall_pct = 38;
      end
    endcase
  endtask

  // Sender: a new pair is offered only once the previous transfer is done, so a
  // stalled payload never changes.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_pairs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off counted here.
  always @(negedge clk_i) begin
    if (hold_start) begin
      hold_left  = HoldCycles;
      hold_start = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < rcv_stall_pct);
  end

  // Monitor: predicts on every accepted pair and checks every accepted result.
  always @(posedge clk_i) begin
    out_t got, want;
    in_took = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        in_took = 1'b1;
        expected_plain.insert(expected_plain.size(), decode_pair(in_data_i));
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (expected_plain.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got));
        end else begin
          want = expected_plain.pop_front();
          check_field("plain_first", 8'(got.plain_first), 8'(want.plain_first));
          check_field("first_valid", 8'(got.first_valid), 8'(want.first_valid));
          check_field("plain_second", 8'(got.plain_second), 8'(want.plain_second));
          check_field("second_valid", 8'(got.second_valid), 8'(want.second_valid));
          check_field("singular_key", 8'(got.singular_key), 8'(want.singular_key));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    key_kind_e              kinds [RandomPhases];
    logic signed [KeyW-1:0] ka, kb, kc, kd;
    int                     pick, scale;
    longint                 p, q;
    in_t                    pair;

    kinds = '{KeySmall, KeyFull, KeyEdge, KeySingular, KeySmall, KeyFull, KeyEdge, KeySmall};

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Identity key: printable bounds, just outside them, and the cipher extremes.
    write_keys(16'sd1, 16'sd0, 16'sd0, 16'sd1);
    queue_pair(encode_pair(32, 126, 0, 0));
    queue_pair(encode_pair(31, 127, 0, 0));
    queue_pair(encode_pair(126, 32, 0, 0));
    queue_pair(encode_pair(0, -1, 0, 0));
    queue_pair(encode_pair(-64'sd2147483648, 64'sd2147483647, 0, 0));
    queue_pair(encode_pair(64'sd2147483647, -64'sd2147483648, 0, 0));
    queue_pair(encode_pair(-32, -126, 0, 0));

    // Negative determinant of -3, with some pairs offset from the exact encoding.
    write_keys(16'sd2, 16'sd1, 16'sd1, -16'sd1);
    queue_pair(encode_pair(72, 105, 0, 0));
    queue_pair(encode_pair(72, 105, 1, 2));
    queue_pair(encode_pair(-72, -105, -1, -1));
    queue_pair(encode_pair(32, 126, 2, -2));

    // Extreme key entries with determinant 65535.
    write_keys(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    queue_pair(encode_pair(32, 126, 0, 0));
    queue_pair(encode_pair(127, 31, 0, 0));
    queue_pair(in_t'{32'h7fff_ffff, 32'h8000_0000});

    // Determinant near the largest magnitude the key width allows.
    write_keys(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768);
    queue_pair(encode_pair(120, 33, 0, 0));
    queue_pair(in_t'{32'h8000_0000, 32'h8000_0000});

    // Singular key: no division, both flags clear.
    write_keys(16'sd4, 16'sd2, 16'sd6, 16'sd3);
    queue_pair(encode_pair(100, 50, 0, 0));
    queue_pair(in_t'{32'h8000_0000, 32'h7fff_ffff});

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (kinds[ph])
        KeySmall: begin
          do begin
            ka = 16'(int'($urandom_range(16)) - 8);
            kb = 16'(int'($urandom_range(16)) - 8);
            kc = 16'(int'($urandom_range(16)) - 8);
            kd = 16'(int'($urandom_range(16)) - 8);
          end while (longint'(ka) * kd == longint'(kb) * kc);
        end
        KeyFull: begin
          ka = 16'($urandom);
          kb = 16'($urandom);
          kc = 16'($urandom);
          kd = 16'($urandom);
        end
        KeyEdge: begin
          ka = -16'sd32768;
          kb = ($urandom_range(1) != 0) ? 16'sd32767 : -16'sd1;
          kc = ($urandom_range(1) != 0) ? 16'sd32767 : 16'sd0;
          kd = ($urandom_range(1) != 0) ? 16'sd32767 : 16'sd1;
        end
        default: begin
          // Columns are multiples of each other, so the determinant is zero.
          scale = int'($urandom_range(6)) - 3;
          kb    = 16'(int'($urandom_range(200)) - 100);
          kd    = 16'(int'($urandom_range(200)) - 100);
          ka    = 16'(scale * int'(kb));
          kc    = 16'(scale * int'(kd));
        end
      endcase
      write_keys(ka, kb, kc, kd);
      set_idle(idle_mode_e'(ph % 4));
      // First random phase: hold the output back while pairs keep coming.
      if (ph == 0) begin
        hold_start = 1'b1;
      end
      repeat (PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          p = longint'($urandom_range(160)) - 16;
          q = longint'($urandom_range(160)) - 16;
          if (pick < 20) begin
            pair = encode_pair(p, q, longint'($urandom_range(6)) - 3,
                               longint'($urandom_range(6)) - 3);
          end else begin
            pair = encode_pair(p, q, 0, 0);
          end
        end else if (pick < 85) begin
          pair.cipher_first  = $urandom;
          pair.cipher_second = $urandom;
        end else begin
          pair.cipher_first  = edge_cipher();
          pair.cipher_second = edge_cipher();
        end
        queue_pair(pair);
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/imd_pkg.sv
design/imd_key.sv
design/imd_rows.sv
design/imd_div.sv
design/integer_matrix_2x2_decrypt.sv
dv/tb_integer_matrix_2x2_decrypt.sv
